[sv/bitmap_first_fit_allocator_assert.svh]
// Assertion macros shared by the bitmap first-fit allocator RTL.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define BFFA_ASSERT_SAME(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BFFA_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`else

`define BFFA_ASSERT_SAME(label, lhs, rhs, msg)
`define BFFA_ASSERT_NEXT(label, lhs, rhs, msg)

`endif

`endif

[sv/bffa_pkg.sv]
// Types, constants and helper functions of the bitmap first-fit allocator.
`default_nettype none

package bffa_pkg;

    // Map geometry.
    localparam int MAX_GRANULES = 1024;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = MAX_GRANULES / WORD_BITS;
    localparam int GRAN_W       = $clog2(MAX_GRANULES);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int WIDX_W       = GRAN_W - BIT_W;
    localparam int AREA_W       = GRAN_W + 1;

    // Field and register widths.
    localparam int LEN_W       = 11;
    localparam int START_W     = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRANULES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST     = 1'b1;

    // Operation codes.
    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_FIT       = 2'd1,
        STATUS_BAD_LENGTH   = 2'd2,
        STATUS_OUT_OF_RANGE = 2'd3
    } status_t;

    // Result of a lowest-set-bit search over one map word.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } ffs_t;

    // Lowest set bit of a map word.
    function automatic ffs_t find_first_set(input logic [WORD_BITS-1:0] v);
        ffs_t r;
        r.found = |v;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r.idx = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/bitmap_first_fit_allocator.sv]
// First-fit contiguous allocator over a one-bit-per-granule occupancy map.
//
// The block keeps 1024 occupancy bits in 32 words of 32 bits, all free after
// reset. An allocate item scans the map from granule 0 for the lowest run of
// run_length free granules inside the managed area, marks it used and returns
// its start; a free item clears run_length bits from free_start. One item is
// worked on at a time and s_axis_tready is high only while the block is idle.
// A rejected item (bad length, range outside the area) goes straight to posting
// its result. A free updates each map word it touches (1 to 32), then posts the
// result. An allocation makes one scan step for each used granule it meets and
// for each map word it passes without one, then marks each word of the run and
// posts the result. The scan uses the single find-first-set and compare unit,
// which looks at one map word per cycle. A finished result waits in the output
// register until taken; the next item is accepted while it waits.
`default_nettype none

module bitmap_first_fit_allocator
    import bffa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // Input items.
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // [10:0] run_length, [20:11] free_start, [23:21] zero
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]             s_axis_tuser,
    // Result items.
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [9:0] run_start, [11:10] status, [15:12] zero
    output      logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    // Registers and their next values.
    state_t                 state_reg,        state_next;
    logic                   op_reg,           op_next;
    logic [LEN_W-1:0]       len_reg,          len_next;
    logic [AREA_W-1:0]      cand_reg,         cand_next;
    logic [AREA_W-1:0]      ptr_reg,          ptr_next;
    logic [AREA_W-1:0]      lo_reg,           lo_next;
    logic [AREA_W-1:0]      hi_reg,           hi_next;
    logic [WIDX_W-1:0]      upd_word_reg,     upd_word_next;
    logic [START_W-1:0]     start_reg,        start_next;
    status_t                status_reg,       status_next;
    logic                   m_valid_reg,      m_valid_next;
    logic [START_W-1:0]     out_start_reg,    out_start_next;
    status_t                out_status_reg,   out_status_next;
    logic [CFG_W-1:0]       granules_reg,     granules_next;
    logic [CFG_W-1:0]       max_request_reg,  max_request_next;

    // Occupancy map, one bit per granule, 1 means used.
    logic [WORD_BITS-1:0]   map_reg [MAP_WORDS];

    // Decoded input fields.
    logic                   in_op;
    logic [LEN_W-1:0]       in_len;
    logic [START_W-1:0]     in_fstart;

    // Shared scan unit.
    logic [AREA_W-1:0]      area;
    logic [WIDX_W-1:0]      ptr_word;
    logic [WORD_BITS-1:0]   scan_word;
    logic [WORD_BITS-1:0]   scan_hits;
    ffs_t                   scan_ffs;
    logic [AREA_W-1:0]      word_base;
    logic [AREA_W-1:0]      word_end;
    logic [AREA_W-1:0]      hit_pos;
    logic [AREA_W:0]        cand_end;
    logic [AREA_W:0]        free_end;

    // Shared range update unit.
    logic [WORD_BITS-1:0]   upd_mask;
    logic [WORD_BITS-1:0]   upd_value;
    logic [AREA_W-1:0]      hi_minus1;
    logic                   upd_last;

    logic                   out_free;

    assign in_op     = s_axis_tuser[0];
    assign in_len    = s_axis_tdata[LEN_W-1:0];
    assign in_fstart = s_axis_tdata[LEN_W+START_W-1:LEN_W];

    // Area size, clipped to the map.
    assign area = (granules_reg > AREA_W'(MAX_GRANULES)) ? AREA_W'(MAX_GRANULES)
                                                          : granules_reg;

    // One map word per cycle: granules below the pointer are ignored and
    // granules beyond the area count as used.
    always_comb
    begin
        ptr_word  = ptr_reg[GRAN_W-1:BIT_W];
        scan_word = map_reg[ptr_word];
        for (int b = 0; b < WORD_BITS; b++)
        begin
            scan_hits[b] = (scan_word[b] | ({1'b0, ptr_word, BIT_W'(b)} >= area))
                           & (BIT_W'(b) >= ptr_reg[BIT_W-1:0]);
        end
        scan_ffs  = find_first_set(scan_hits);
        word_base = {1'b0, ptr_word, {BIT_W{1'b0}}};
        word_end  = word_base + AREA_W'(WORD_BITS);
        hit_pos   = {1'b0, ptr_word, scan_ffs.idx};
        cand_end  = {1'b0, cand_reg} + (AREA_W + 1)'(len_reg);
    end

    // Bits of the current word that fall inside [lo, hi).
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            upd_mask[b] = ({1'b0, upd_word_reg, BIT_W'(b)} >= lo_reg)
                          && ({1'b0, upd_word_reg, BIT_W'(b)} < hi_reg);
        end
        upd_value = (op_reg == OP_ALLOC) ? (map_reg[upd_word_reg] | upd_mask)
                                         : (map_reg[upd_word_reg] & ~upd_mask);
        hi_minus1 = hi_reg - AREA_W'(1);
        upd_last  = (upd_word_reg == hi_minus1[GRAN_W-1:BIT_W]);
    end

    assign free_end      = (AREA_W + 1)'(in_fstart) + (AREA_W + 1)'(in_len);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - START_W - 2){1'b0}}, out_status_reg,
                            out_start_reg};

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        len_next         = len_reg;
        cand_next        = cand_reg;
        ptr_next         = ptr_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        upd_word_next    = upd_word_reg;
        start_next       = start_reg;
        status_next      = status_reg;
        m_valid_next     = m_valid_reg;
        out_start_next   = out_start_reg;
        out_status_next  = out_status_reg;
        granules_next    = granules_reg;
        max_request_next = max_request_reg;

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRANULES_IN_USE: granules_next    = cfg_data;
                REG_MAX_REQUEST:     max_request_next = cfg_data;
                default:             ;
            endcase
        end

        // A taken result frees the output register.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = in_op;
                    len_next    = in_len;
                    start_next  = '0;
                    status_next = STATUS_OK;
                    if (in_len == '0 || in_len > max_request_reg)
                    begin
                        status_next = STATUS_BAD_LENGTH;
                        state_next  = ST_RESP;
                    end
                    else if (in_op == OP_ALLOC)
                    begin
                        cand_next  = '0;
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (free_end > (AREA_W + 1)'(area))
                    begin
                        status_next = STATUS_OUT_OF_RANGE;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        lo_next       = AREA_W'(in_fstart);
                        hi_next       = free_end[AREA_W-1:0];
                        upd_word_next = in_fstart[GRAN_W-1:BIT_W];
                        state_next    = ST_UPDATE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cand_end > (AREA_W + 1)'(area))
                begin
                    status_next = STATUS_NO_FIT;
                    start_next  = '0;
                    state_next  = ST_RESP;
                end
                else if ((scan_ffs.found && (hit_pos - cand_reg) >= AREA_W'(len_reg))
                         || (!scan_ffs.found && (word_end - cand_reg) >= AREA_W'(len_reg)))
                begin
                    // The run from the candidate start is long enough.
                    start_next    = cand_reg[START_W-1:0];
                    lo_next       = cand_reg;
                    hi_next       = cand_end[AREA_W-1:0];
                    upd_word_next = cand_reg[GRAN_W-1:BIT_W];
                    state_next    = ST_UPDATE;
                end
                else if (scan_ffs.found)
                begin
                    // Restart just past the used granule.
                    cand_next = hit_pos + AREA_W'(1);
                    ptr_next  = hit_pos + AREA_W'(1);
                end
                else
                begin
                    ptr_next = word_end;
                end
            end

            ST_UPDATE:
            begin
                if (upd_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    upd_word_next = upd_word_reg + WIDX_W'(1);
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_start_next  = start_reg;
                    out_status_next = status_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, registered outputs and the occupancy map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            granules_reg    <= CFG_W'(1024);
            max_request_reg <= CFG_W'(1024);
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            granules_reg    <= granules_next;
            max_request_reg <= max_request_next;
            if (state_reg == ST_UPDATE)
            begin
                map_reg[upd_word_reg] <= upd_value;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        len_reg        <= len_next;
        cand_reg       <= cand_next;
        ptr_reg        <= ptr_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        upd_word_reg   <= upd_word_next;
        start_reg      <= start_next;
        status_reg     <= status_next;
        out_start_reg  <= out_start_next;
        out_status_reg <= out_status_next;
    end

    `include "bitmap_first_fit_allocator_assert.svh"

    // The scan pointer never falls behind the candidate start.
    `BFFA_ASSERT_SAME(a_ptr_ahead, state_reg == ST_SCAN, ptr_reg >= cand_reg,
                      "scan pointer behind candidate")

    // A range update covers a non-empty run inside the area.
    `BFFA_ASSERT_SAME(a_upd_range, state_reg == ST_UPDATE,
                      (lo_reg < hi_reg) && (hi_reg <= area),
                      "update range outside area")

    // A failed or rejected result reports start zero.
    `BFFA_ASSERT_SAME(a_fail_start, m_valid_reg && (out_status_reg != STATUS_OK),
                      out_start_reg == '0, "failed result with nonzero start")

    // A result posted while the output was busy would overwrite it.
    `BFFA_ASSERT_NEXT(a_no_overwrite,
                      (state_reg == ST_RESP) && m_valid_reg && !m_axis_tready,
                      state_reg == ST_RESP, "result posted over a waiting result")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the bitmap first-fit allocator.
module tb_top
    import bffa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Expected result item of one request.
    typedef struct packed {
        logic [START_W-1:0] run_start;
        status_t            status;
    } grant_t;

    // A run that the stimulus believes is allocated.
    typedef struct packed {
        logic [START_W-1:0] base;
        logic [LEN_W-1:0]   span;
    } live_run_t;

    // Idle patterns of the two stream sides.
    typedef enum int {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    // Mirror of the occupancy map that predicts each grant and checks it.
    class grant_scoreboard;
        bit [MAX_GRANULES-1:0] occupied;
        bit [CFG_W-1:0]        area_reg;
        bit [CFG_W-1:0]        limit_reg;
        grant_t                pending_grants[$];
        int unsigned           errors;

        function new();
            occupied  = '0;
            area_reg  = CFG_W'(MAX_GRANULES);
            limit_reg = CFG_W'(MAX_GRANULES);
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_GRANULES_IN_USE)
            begin
                area_reg = value;
            end
            else
            begin
                limit_reg = value;
            end
        endfunction

        // Works out the grant of an accepted item and updates the map.
        function grant_t note_request(logic op, logic [LEN_W-1:0] len,
                                      logic [START_W-1:0] fstart);
            grant_t      r;
            int unsigned area;
            int unsigned run;
            int unsigned g;
            area = (area_reg > MAX_GRANULES) ? MAX_GRANULES : area_reg;
            r.run_start = '0;
            r.status    = STATUS_OK;
            if (len == 0 || len > limit_reg)
            begin
                r.status = STATUS_BAD_LENGTH;
            end
            else if (op == OP_ALLOC)
            begin
                r.status = STATUS_NO_FIT;
                if (len <= area)
                begin
                    // First fit: lowest start with len free granules in the area.
                    run = 0;
                    for (g = 0; g < area; g++)
                    begin
                        if (occupied[g])
                        begin
                            run = 0;
                        end
                        else
                        begin
                            run++;
                            if (run == len)
                            begin
                                r.run_start = START_W'(g + 1 - len);
                                r.status    = STATUS_OK;
                                break;
                            end
                        end
                    end
                    if (r.status == STATUS_OK)
                    begin
                        for (g = r.run_start; g < r.run_start + len; g++)
                        begin
                            occupied[g] = 1'b1;
                        end
                    end
                end
            end
            else if (fstart + len > area)
            begin
                r.status = STATUS_OUT_OF_RANGE;
            end
            else
            begin
                for (g = fstart; g < fstart + len; g++)
                begin
                    occupied[g] = 1'b0;
                end
            end
            pending_grants.push_back(r);
            return r;
        endfunction

        // Compares a result item with the oldest expected grant.
        function void check_grant(logic [OUT_DATA_W-1:0] data);
            grant_t             want;
            logic [START_W-1:0] got_start;
            logic [1:0]         got_status;
            got_start  = data[START_W-1:0];
            got_status = data[START_W+1:START_W];
            if (pending_grants.size() == 0)
            begin
                $display("%0t: result with none expected, got run_start %0d status %0d",
                         $time, got_start, got_status);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            if (got_start !== want.run_start)
            begin
                $display("%0t: run_start mismatch, expected %0d, got %0d",
                         $time, want.run_start, got_start);
                errors++;
            end
            if (got_status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d (%s), got %0d",
                         $time, want.status, want.status.name(), got_status);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GRANULES_IN_USE;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [10:0] run_length, [20:11] free_start, [23:21] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] operation
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [9:0] run_start, [11:10] status, [15:12] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    grant_scoreboard board;
    live_run_t       live_runs[$];
    int unsigned     send_gap_pct = 0;
    int unsigned     stall_pct = 0;
    logic            hold_active = 1'b0;
    event            hold_off_go;

    bitmap_first_fit_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is running.
    always @(negedge clk)
    begin
        if (hold_active)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Long receiver hold-off, counted here while the sender keeps going.
    initial
    begin
        forever
        begin
            @(hold_off_go);
            hold_active <= 1'b1;
            repeat (400) @(negedge clk);
            hold_active <= 1'b0;
        end
    end

    // Every result item taken is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_grant(m_axis_tdata);
        end
    end

    // Offers one item, waits for it to be taken and records its grant.
    task automatic send_request(input logic op, input logic [LEN_W-1:0] len,
                                input logic [START_W-1:0] fstart);
        grant_t grant;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, fstart, len};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        grant = board.note_request(op, len, fstart);
        if (op == OP_ALLOC && grant.status == STATUS_OK)
        begin
            live_runs.push_back('{base: grant.run_start, span: len});
        end
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected grant has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_grants.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic configure(input logic [CFG_W-1:0] area, input logic [CFG_W-1:0] limit);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRANULES_IN_USE;
        cfg_data  <= area;
        board.write_reg(REG_GRANULES_IN_USE, area);
        @(negedge clk);
        cfg_index <= REG_MAX_REQUEST;
        cfg_data  <= limit;
        board.write_reg(REG_MAX_REQUEST, limit);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly allocations and frees of live runs, with some malformed noise.
    task automatic random_request();
        int unsigned      pick;
        int unsigned      cap;
        int unsigned      idx;
        logic             op;
        logic [LEN_W-1:0] len;
        logic [START_W-1:0] fstart;
        pick   = $urandom_range(0, 99);
        fstart = START_W'($urandom);
        if (pick < 15)
        begin
            op  = 1'($urandom);
            len = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40));
        end
        else if (live_runs.size() != 0 && (pick < 45 || live_runs.size() > 48))
        begin
            idx    = $urandom_range(0, live_runs.size() - 1);
            op     = OP_FREE;
            fstart = live_runs[idx].base;
            len    = live_runs[idx].span;
            live_runs.delete(idx);
        end
        else
        begin
            op  = OP_ALLOC;
            cap = (board.limit_reg > MAX_GRANULES) ? MAX_GRANULES : board.limit_reg;
            if (cap == 0)
            begin
                cap = 1;
            end
            if ($urandom_range(0, 9) != 0 && cap > 24)
            begin
                cap = 24;
            end
            len = LEN_W'($urandom_range(1, cap));
        end
        send_request(op, len, fstart);
    endtask

    // Run limit.
    initial
    begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset, directed items, then random phases.
    initial
    begin
        int unsigned      phase;
        int unsigned      k;
        logic [CFG_W-1:0] area;
        logic [CFG_W-1:0] limit;
        pace_t            pace;
        board = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero and oversize lengths, full map, range past the end, freeing free granules.
        send_request(OP_ALLOC, 11'd0, 10'd1023);
        send_request(OP_FREE, 11'd0, 10'd0);
        send_request(OP_ALLOC, 11'd1025, 10'd0);
        send_request(OP_FREE, 11'd2047, 10'd0);
        send_request(OP_ALLOC, 11'd1, 10'd1023);
        send_request(OP_ALLOC, 11'd1023, 10'd0);
        send_request(OP_ALLOC, 11'd1, 10'd0);
        send_request(OP_FREE, 11'd2, 10'd1023);
        send_request(OP_FREE, 11'd1, 10'd1);
        send_request(OP_FREE, 11'd1, 10'd1);
        send_request(OP_ALLOC, 11'd1, 10'd0);
        send_request(OP_FREE, 11'd1024, 10'd0);
        send_request(OP_ALLOC, 11'd1024, 10'd0);
        send_request(OP_FREE, 11'd1024, 10'd0);

        // A hole too small for the next request is skipped.
        send_request(OP_ALLOC, 11'd8, 10'd0);
        send_request(OP_ALLOC, 11'd8, 10'd0);
        send_request(OP_FREE, 11'd8, 10'd0);
        send_request(OP_ALLOC, 11'd4, 10'd0);
        send_request(OP_ALLOC, 11'd8, 10'd0);

        // Empty area.
        configure(11'd0, 11'd2047);
        send_request(OP_ALLOC, 11'd1, 10'd0);
        send_request(OP_FREE, 11'd1, 10'd0);

        // A zero length limit rejects everything.
        configure(11'd16, 11'd0);
        send_request(OP_ALLOC, 11'd1, 10'd0);

        // Shrunk area: longer than the area, and used bits beyond it kept.
        configure(11'd16, 11'd2047);
        send_request(OP_ALLOC, 11'd17, 10'd0);
        send_request(OP_FREE, 11'd1, 10'd20);
        send_request(OP_ALLOC, 11'd4, 10'd0);

        // Random phases over several settings and idle patterns.
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin area = 11'd1024; limit = 11'd1024; end
                1: begin area = 11'd2047; limit = 11'd64;   end
                2: begin area = 11'd64;   limit = 11'd16;   end
                3: begin area = 11'd256;  limit = 11'd2047; end
                4: begin area = 11'd1024; limit = 11'd32;   end
                5: begin area = 11'd1;    limit = 11'd1;    end
                6: begin area = 11'd500;  limit = 11'd200;  end
                default: begin area = 11'd1024; limit = 11'd1024; end
            endcase
            configure(area, limit);
            pace = pace_t'(phase % 4);
            case (pace)
                PACE_STEADY:          begin send_gap_pct = 0;  stall_pct = 0;  end
                PACE_SENDER_GAPS:     begin send_gap_pct = 64; stall_pct = 0;  end
                PACE_RECEIVER_STALLS: begin send_gap_pct = 0;  stall_pct = 64; end
                default:              begin send_gap_pct = 16; stall_pct = 16; end
            endcase
            // Back pressure: the receiver holds off while items keep coming.
            if (phase == 4)
            begin
                -> hold_off_go;
            end
            for (k = 0; k < 220; k++)
            begin
                random_request();
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
